// ----- rtl/core/grid_bilinear_interp_extrap_macros.svh -----
// Assertion macros shared by the checker.
`ifndef GRID_BILINEAR_INTERP_EXTRAP_MACROS_SVH
`define GRID_BILINEAR_INTERP_EXTRAP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GBIE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gbie assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GBIE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gbie assertion failed");

`endif

// ----- rtl/core/gbie_pkg.sv -----
package gbie_pkg;

	typedef enum logic [1:0] {
		REQ_ROW_BP = 2'd0,
		REQ_COL_BP = 2'd1,
		REQ_CELL   = 2'd2,
		REQ_QUERY  = 2'd3
	} req_t;

	localparam logic CFG_ROW_USED = 1'b0;
	localparam logic CFG_COL_USED = 1'b1;

	localparam int FRAC_BITS = 16;
	localparam int ACC_BITS  = 14;
	localparam int NW        = 24;
	localparam int QW        = NW + FRAC_BITS;
	localparam int MAGW      = 63;
	localparam int DIGW      = 8;
	localparam int PRODW     = MAGW + QW;

	localparam logic [63:0] ACC_LIM  = 64'h2000_0000_0000_0000;
	localparam logic [63:0] OUT_MAX  = 64'h0000_7FFF_FFFF_FFFF;
	localparam logic [QW-1:0] FRAC_ONE = 40'h00_0001_0000;

	typedef struct packed {
		logic          start;
		logic [NW-1:0] num;
		logic [NW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic            start;
		logic [MAGW-1:0] mag;
		logic [QW-1:0]   w;
	} mul_req_t;

endpackage

// ----- rtl/core/grid_bilinear_interp_extrap.sv -----
// Table writes never stall the input; a new request may follow in the next cycle.
// A query runs serial breakpoint scans over the R row and C column points in use, the
// one-bit-per-cycle divider at most once per axis and three multiply steps on the shared unit.
// A zero coordinate goes straight to the result; a coordinate below the first breakpoint
// ends the query once the first point of its axis scan is read.
// Reset clears control state and sets both point counts to 2; breakpoints and cells stay undefined.
module grid_bilinear_interp_extrap #(
	parameter int MAX_ROW_POINTS = 16,
	parameter int MAX_COL_POINTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         req_type,
	input  logic [3:0]         row_index,
	input  logic [3:0]         col_index,
	input  logic [31:0]        write_value,
	input  logic [23:0]        query_n,
	input  logic [15:0]        query_k,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [47:0] latency_ns,
	output logic               status,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [4:0]         cfg_data
);

	localparam int MAXP   = (MAX_ROW_POINTS > MAX_COL_POINTS) ? MAX_ROW_POINTS : MAX_COL_POINTS;
	localparam int IW     = $clog2(MAXP);
	localparam int UW     = IW + 1;
	localparam int RAW    = $clog2(MAX_ROW_POINTS);
	localparam int CAW    = $clog2(MAX_COL_POINTS);
	localparam int TDEPTH = MAX_ROW_POINTS * MAX_COL_POINTS;
	localparam int TAW    = $clog2(TDEPTH);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_SCAN   = 9'b000000010,
		S_DIV    = 9'b000000100,
		S_FETCH  = 9'b000001000,
		S_PREP   = 9'b000010000,
		S_MUL    = 9'b000100000,
		S_TERM   = 9'b001000000,
		S_SUM    = 9'b010000000,
		S_FINISH = 9'b100000000
	} state_t;

	typedef enum logic [1:0] {
		FRAC_DIV  = 2'd0,
		FRAC_ZERO = 2'd1,
		FRAC_FULL = 2'd2
	} frac_mode_t;

	function automatic logic [UW-1:0] clamp_used(input logic [4:0] r, input int mx);
		if (r < 5'd2) return UW'(2);
		if (32'(r) > mx) return UW'(mx);
		return UW'(r);
	endfunction

	function automatic logic signed [63:0] cell_val(input logic [31:0] c);
		return $signed({18'b0, c, 14'b0});
	endfunction

	logic [23:0] row_mem [MAX_ROW_POINTS];
	logic [15:0] col_mem [MAX_COL_POINTS];
	logic [31:0] tab_mem [TDEPTH];

	state_t              state_q;
	logic [4:0]          row_used_q, col_used_q;
	logic [UW-1:0]       nr, nc, used;
	logic [IW-1:0]       last_idx;
	logic                accept;
	logic [23:0]         n_q;
	logic [15:0]         k_q;
	logic                axis_q, err_q, zero_q;
	logic [23:0]         x, v;
	logic [IW-1:0]       scan_idx_q, rd_idx_q;
	logic                issue_q, rd_vld_q;
	logic [23:0]         row_rd_q;
	logic [15:0]         col_rd_q;
	logic [23:0]         prev_q, lo_val_q, hi_val_q;
	logic                found_q;
	logic [IW-1:0]       lo_idx_q;
	logic                found_now;
	logic [23:0]         lo_val_now, hi_val_now;
	logic [IW-1:0]       lo_idx_now;
	logic [IW-1:0]       lo_sel;
	logic                within_sel;
	logic [23:0]         num_sel, den_sel;
	frac_mode_t          mode_sel, fmode_q;
	logic [23:0]         div_num_q, div_den_q;
	logic                div_sent_q;
	logic                frac_rdy;
	logic [39:0]         frac_val;
	logic [IW-1:0]       nlo_q, clo_q;
	logic                n_within_q, k_within_q;
	logic [39:0]         fn_q, fk_q;
	logic [2:0]          fetch_q;
	logic [31:0]         c00_q, c01_q, c10_q, c11_q, tab_rd_q;
	logic [IW-1:0]       fr, fc;
	logic [TAW-1:0]      tab_raddr, tab_waddr;
	logic [1:0]          step_q;
	logic                case_a;
	logic signed [63:0]  op_a, op_b, diff_q, base_q, term_q, s0_q, s1_q, r_q;
	logic signed [63:0]  term, sum, sum_cl, ns;
	logic [39:0]         op_w;
	logic                op_ext;
	logic                mul_sent_q;
	logic                tsat;
	logic [63:0]         tq, tq_inc, tq_cl;
	logic [47:0]         ns_cl;

	gbie_pkg::div_req_t  div_req;
	logic                div_done;
	logic [39:0]         div_quot;
	gbie_pkg::mul_req_t  mul_req;
	logic                mul_done;
	logic [gbie_pkg::PRODW-1:0] mul_prod;

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = in_valid & ~in_stall;

	assign nr       = clamp_used(row_used_q, MAX_ROW_POINTS);
	assign nc       = clamp_used(col_used_q, MAX_COL_POINTS);
	assign used     = axis_q ? nc : nr;
	assign last_idx = IW'(used - UW'(1));
	assign x        = axis_q ? {8'b0, k_q} : n_q;
	assign v        = axis_q ? {8'b0, col_rd_q} : row_rd_q;

	always_comb begin
		found_now  = found_q | (v > x);
		lo_val_now = found_q ? lo_val_q : prev_q;
		hi_val_now = found_q ? hi_val_q : v;
		lo_idx_now = found_q ? lo_idx_q : IW'(rd_idx_q - 1'b1);
		if (x > v) begin
			within_sel = 1'b0;
			lo_sel     = IW'(last_idx - 1'b1);
			num_sel    = x - v;
			den_sel    = v - prev_q;
			mode_sel   = (v > prev_q) ? FRAC_DIV : FRAC_ZERO;
		end else if (found_now) begin
			within_sel = 1'b1;
			lo_sel     = lo_idx_now;
			num_sel    = x - lo_val_now;
			den_sel    = hi_val_now - lo_val_now;
			mode_sel   = FRAC_DIV;
		end else begin
			within_sel = 1'b1;
			lo_sel     = IW'(last_idx - 1'b1);
			num_sel    = '0;
			den_sel    = '0;
			mode_sel   = FRAC_FULL;
		end
	end

	always_comb begin
		case (fmode_q)
			FRAC_ZERO: begin
				frac_rdy = 1'b1;
				frac_val = '0;
			end
			FRAC_FULL: begin
				frac_rdy = 1'b1;
				frac_val = gbie_pkg::FRAC_ONE;
			end
			default: begin
				frac_rdy = div_sent_q & div_done;
				frac_val = div_quot;
			end
		endcase
	end

	assign div_req.start = (state_q == S_DIV) && (fmode_q == FRAC_DIV) && !div_sent_q;
	assign div_req.num   = div_num_q;
	assign div_req.den   = div_den_q;

	gbie_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign fr        = fetch_q[1] ? IW'(nlo_q + 1'b1) : nlo_q;
	assign fc        = fetch_q[0] ? IW'(clo_q + 1'b1) : clo_q;
	assign tab_raddr = TAW'(fr) * TAW'(MAX_COL_POINTS) + TAW'(fc);
	assign tab_waddr = TAW'(row_index) * TAW'(MAX_COL_POINTS) + TAW'(col_index);

	always_ff @(posedge clk) begin
		if (accept && req_type == gbie_pkg::REQ_ROW_BP && 32'(row_index) < MAX_ROW_POINTS) begin
			row_mem[RAW'(row_index)] <= write_value[23:0];
		end
		row_rd_q <= row_mem[RAW'(scan_idx_q)];
	end

	always_ff @(posedge clk) begin
		if (accept && req_type == gbie_pkg::REQ_COL_BP && 32'(col_index) < MAX_COL_POINTS) begin
			col_mem[CAW'(col_index)] <= write_value[15:0];
		end
		col_rd_q <= col_mem[CAW'(scan_idx_q)];
	end

	always_ff @(posedge clk) begin
		if (accept && req_type == gbie_pkg::REQ_CELL && 32'(row_index) < MAX_ROW_POINTS
			&& 32'(col_index) < MAX_COL_POINTS) begin
			tab_mem[tab_waddr] <= write_value;
		end
		tab_rd_q <= tab_mem[tab_raddr];
	end

	assign case_a = n_within_q & ~k_within_q;

	always_comb begin
		case (step_q)
			2'd0: begin
				op_a   = cell_val(c00_q);
				op_b   = case_a ? cell_val(c01_q) : cell_val(c10_q);
				op_w   = case_a ? fk_q : fn_q;
				op_ext = case_a | ~n_within_q;
			end
			2'd1: begin
				op_a   = case_a ? cell_val(c10_q) : cell_val(c01_q);
				op_b   = cell_val(c11_q);
				op_w   = case_a ? fk_q : fn_q;
				op_ext = case_a | ~n_within_q;
			end
			default: begin
				op_a   = s0_q;
				op_b   = s1_q;
				op_w   = case_a ? fn_q : fk_q;
				op_ext = ~case_a & ~k_within_q;
			end
		endcase
	end

	assign mul_req.start = (state_q == S_MUL) && !mul_sent_q;
	assign mul_req.mag   = gbie_pkg::MAGW'(diff_q[63] ? -diff_q : diff_q);
	assign mul_req.w     = op_w;

	gbie_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	always_comb begin
		tsat   = |mul_prod[gbie_pkg::PRODW-1:80];
		tq     = mul_prod[79:16];
		tq_inc = tq + 64'(diff_q[63] && (mul_prod[15:0] != 16'd0));
		if (tsat || tq > gbie_pkg::ACC_LIM || tq_inc > gbie_pkg::ACC_LIM) begin
			tq_cl = gbie_pkg::ACC_LIM;
		end else begin
			tq_cl = tq_inc;
		end
		term = diff_q[63] ? -$signed(tq_cl) : $signed(tq_cl);
	end

	always_comb begin
		sum = base_q + term_q;
		if (sum > $signed(gbie_pkg::ACC_LIM)) begin
			sum_cl = $signed(gbie_pkg::ACC_LIM);
		end else if (sum < -$signed(gbie_pkg::ACC_LIM)) begin
			sum_cl = -$signed(gbie_pkg::ACC_LIM);
		end else begin
			sum_cl = sum;
		end
		ns    = r_q >>> gbie_pkg::ACC_BITS;
		ns_cl = (ns > $signed(gbie_pkg::OUT_MAX)) ? gbie_pkg::OUT_MAX[47:0] : ns[47:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			row_used_q <= 5'd2;
			col_used_q <= 5'd2;
			out_valid  <= 1'b0;
			issue_q    <= 1'b0;
			rd_vld_q   <= 1'b0;
			div_sent_q <= 1'b0;
			mul_sent_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					gbie_pkg::CFG_ROW_USED: row_used_q <= cfg_data;
					gbie_pkg::CFG_COL_USED: col_used_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall && state_q != S_FINISH) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && req_type == gbie_pkg::REQ_QUERY) begin
						n_q        <= query_n;
						k_q        <= query_k;
						axis_q     <= 1'b0;
						err_q      <= 1'b0;
						zero_q     <= (query_n == 24'd0) || (query_k == 16'd0);
						scan_idx_q <= '0;
						issue_q    <= 1'b1;
						rd_vld_q   <= 1'b0;
						found_q    <= 1'b0;
						if (query_n == 24'd0 || query_k == 16'd0) begin
							state_q <= S_FINISH;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					rd_vld_q <= issue_q;
					rd_idx_q <= scan_idx_q;
					if (issue_q) begin
						if (scan_idx_q == last_idx) begin
							issue_q <= 1'b0;
						end else begin
							scan_idx_q <= scan_idx_q + 1'b1;
						end
					end
					if (rd_vld_q) begin
						prev_q <= v;
						if (!found_q && v > x) begin
							found_q  <= 1'b1;
							lo_val_q <= prev_q;
							hi_val_q <= v;
							lo_idx_q <= IW'(rd_idx_q - 1'b1);
						end
						if (rd_idx_q == '0 && x < v) begin
							err_q   <= 1'b1;
							state_q <= S_FINISH;
						end else if (rd_idx_q == last_idx) begin
							if (!axis_q) begin
								nlo_q      <= lo_sel;
								n_within_q <= within_sel;
							end else begin
								clo_q      <= lo_sel;
								k_within_q <= within_sel;
							end
							div_num_q  <= num_sel;
							div_den_q  <= den_sel;
							fmode_q    <= mode_sel;
							div_sent_q <= 1'b0;
							state_q    <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (div_req.start) begin
						div_sent_q <= 1'b1;
					end
					if (frac_rdy) begin
						if (!axis_q) begin
							fn_q       <= frac_val;
							axis_q     <= 1'b1;
							scan_idx_q <= '0;
							issue_q    <= 1'b1;
							rd_vld_q   <= 1'b0;
							found_q    <= 1'b0;
							state_q    <= S_SCAN;
						end else begin
							fk_q    <= frac_val;
							fetch_q <= '0;
							state_q <= S_FETCH;
						end
					end
				end
				S_FETCH: begin
					fetch_q <= fetch_q + 1'b1;
					case (fetch_q)
						3'd1: c00_q <= tab_rd_q;
						3'd2: c01_q <= tab_rd_q;
						3'd3: c10_q <= tab_rd_q;
						3'd4: begin
							c11_q   <= tab_rd_q;
							step_q  <= 2'd0;
							state_q <= S_PREP;
						end
						default: ;
					endcase
				end
				S_PREP: begin
					diff_q     <= op_b - op_a;
					base_q     <= op_ext ? op_b : op_a;
					mul_sent_q <= 1'b0;
					state_q    <= S_MUL;
				end
				S_MUL: begin
					if (!mul_sent_q) begin
						mul_sent_q <= 1'b1;
					end else if (mul_done) begin
						state_q <= S_TERM;
					end
				end
				S_TERM: begin
					term_q  <= term;
					state_q <= S_SUM;
				end
				S_SUM: begin
					case (step_q)
						2'd0: s0_q <= sum_cl;
						2'd1: s1_q <= sum_cl;
						default: r_q <= sum_cl;
					endcase
					if (step_q == 2'd2) begin
						state_q <= S_FINISH;
					end else begin
						step_q  <= step_q + 1'b1;
						state_q <= S_PREP;
					end
				end
				S_FINISH: begin
					if (!out_valid || !out_stall) begin
						out_valid  <= 1'b1;
						latency_ns <= (err_q || zero_q) ? 48'sd0 : $signed(ns_cl);
						status     <= err_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/core/gbie_div.sv -----
module gbie_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gbie_pkg::div_req_t          req,
	output logic                        done,
	output logic [gbie_pkg::QW-1:0]     quot
);

	localparam int CNTW = $clog2(gbie_pkg::QW);

	logic                      busy_q;
	logic                      done_q;
	logic [CNTW-1:0]           cnt_q;
	logic [gbie_pkg::NW:0]     rem_q;
	logic [gbie_pkg::QW-1:0]   quo_q;
	logic [gbie_pkg::NW-1:0]   den_q;
	logic [gbie_pkg::NW:0]     rem_sh;
	logic [gbie_pkg::NW:0]     rem_nx;
	logic                      ge;

	always_comb begin
		rem_sh = {rem_q[gbie_pkg::NW-1:0], quo_q[gbie_pkg::QW-1]};
		ge     = rem_sh >= {1'b0, den_q};
		rem_nx = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNTW'(gbie_pkg::QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= {req.num, {gbie_pkg::FRAC_BITS{1'b0}}};
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[gbie_pkg::QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

// ----- rtl/core/gbie_mul.sv -----
module gbie_mul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  gbie_pkg::mul_req_t           req,
	output logic                         done,
	output logic [gbie_pkg::PRODW-1:0]   prod
);

	localparam int DIGITS = gbie_pkg::QW / gbie_pkg::DIGW;
	localparam int CNTW   = $clog2(DIGITS);
	localparam int PPW    = gbie_pkg::MAGW + gbie_pkg::DIGW;

	logic                          busy_q;
	logic                          done_q;
	logic [CNTW-1:0]               cnt_q;
	logic [gbie_pkg::MAGW-1:0]     mag_q;
	logic [gbie_pkg::QW-1:0]       w_q;
	logic [gbie_pkg::PRODW-1:0]    acc_q;
	logic [PPW-1:0]                pp;
	logic [gbie_pkg::PRODW-1:0]    acc_nx;

	always_comb begin
		pp     = PPW'(mag_q) * PPW'(w_q[gbie_pkg::QW-1 -: gbie_pkg::DIGW]);
		acc_nx = {acc_q[gbie_pkg::PRODW-gbie_pkg::DIGW-1:0], {gbie_pkg::DIGW{1'b0}}}
			+ gbie_pkg::PRODW'(pp);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNTW'(DIGITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			mag_q <= req.mag;
			w_q   <= req.w;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_nx;
			w_q   <= {w_q[gbie_pkg::QW-gbie_pkg::DIGW-1:0], {gbie_pkg::DIGW{1'b0}}};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// ----- rtl/core/gbie_checker.sv -----
`include "grid_bilinear_interp_extrap_macros.svh"

module gbie_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic [1:0]         req_type,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [47:0] latency_ns,
	input logic               status
);

	// A request below range never carries a latency.
	`GBIE_ASSERT_IMP(a_err_zero, clk, arst_n, out_valid && status, latency_ns == 48'sd0)

	`GBIE_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(latency_ns) && $stable(status))

	// A query occupies the block, a table write does not.
	`GBIE_ASSERT_NXT(a_query_busy, clk, arst_n, in_valid && !in_stall && req_type == gbie_pkg::REQ_QUERY, in_stall)

	`GBIE_ASSERT_NXT(a_write_free, clk, arst_n, in_valid && !in_stall && req_type != gbie_pkg::REQ_QUERY, !in_stall)

endmodule

bind grid_bilinear_interp_extrap gbie_checker u_gbie_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.req_type   (req_type),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.latency_ns (latency_ns),
	.status     (status)
);

// ----- tb/tb_grid_bilinear_interp_extrap.sv -----
`timescale 1ns / 1ps

module tb_grid_bilinear_interp_extrap;

	localparam int PTS = 16;
	localparam int LIMIT_CYCLES = 3000000;
	localparam int DRAIN_CYCLES = 200;
	localparam logic signed [63:0] SAT_LIM = 64'sh2000_0000_0000_0000;

	typedef struct {
		gbie_pkg::req_t kind;
		logic [3:0]     ri;
		logic [3:0]     ci;
		logic [31:0]    wv;
		logic [23:0]    n;
		logic [15:0]    k;
	} request_t;

	typedef struct {
		logic signed [47:0] lat;
		logic               st;
	} estimate_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         req_type;
	logic [3:0]         row_index;
	logic [3:0]         col_index;
	logic [31:0]        write_value;
	logic [23:0]        query_n;
	logic [15:0]        query_k;
	logic               out_valid;
	logic               out_stall;
	logic signed [47:0] latency_ns;
	logic               status;
	logic               cfg_valid;
	logic               cfg_ready;
	logic               cfg_index;
	logic [4:0]         cfg_data;

	logic [23:0] row_bp [PTS];
	logic [15:0] col_bp [PTS];
	logic [31:0] lat_tab [PTS][PTS];
	logic [4:0]  rows_reg;
	logic [4:0]  cols_reg;

	estimate_t pending_estimates [$];
	int errors;
	int cycles;
	int idle_pct;
	int stall_pct;
	int hold_cnt;

	grid_bilinear_interp_extrap u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .row_index(row_index), .col_index(col_index),
		.write_value(write_value), .query_n(query_n), .query_k(query_k),
		.out_valid(out_valid), .out_stall(out_stall),
		.latency_ns(latency_ns), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("** grid_bilinear_interp_extrap: FAILED **");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (hold_cnt > 0) begin
			out_stall <= 1'b1;
			hold_cnt <= hold_cnt - 1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	function automatic int points_in_use(logic [4:0] r);
		if (r < 2) return 2;
		if (r > PTS) return PTS;
		return r;
	endfunction

	function automatic logic [63:0] span_fraction(logic [31:0] num, logic [31:0] lo,
			logic [31:0] hi);
		logic [63:0] wide;
		if (hi <= lo) return 64'd0;
		wide = {32'd0, num} << gbie_pkg::FRAC_BITS;
		return wide / {32'd0, hi - lo};
	endfunction

	function automatic void bracket(input bit is_row, input logic [31:0] x,
			output int lo, output int hi, output logic [63:0] frac, output bit in_grid);
		logic [31:0] bp [PTS];
		int used;
		int i;
		used = is_row ? points_in_use(rows_reg) : points_in_use(cols_reg);
		for (int j = 0; j < PTS; j++)
			bp[j] = is_row ? {8'd0, row_bp[j]} : {16'd0, col_bp[j]};
		lo = used - 2;
		hi = used - 1;
		if (x > bp[used - 1]) begin
			in_grid = 1'b0;
			frac = span_fraction(x - bp[used - 1], bp[used - 2], bp[used - 1]);
			return;
		end
		in_grid = 1'b1;
		i = 0;
		while (i < used && bp[i] <= x)
			i++;
		if (i >= used) begin
			frac = 64'd1 << gbie_pkg::FRAC_BITS;
		end else begin
			hi = i;
			lo = i - 1;
			frac = span_fraction(x - bp[i - 1], bp[i - 1], bp[i]);
		end
	endfunction

	function automatic logic signed [63:0] clamp_acc(logic signed [63:0] v);
		if (v > SAT_LIM) return SAT_LIM;
		if (v < -SAT_LIM) return -SAT_LIM;
		return v;
	endfunction

	function automatic logic signed [63:0] scale_frac(logic signed [63:0] a, logic [63:0] w);
		bit neg;
		logic [63:0] mag;
		logic [127:0] prod;
		logic [63:0] q;
		neg = a < 0;
		mag = neg ? -a : a;
		prod = {64'd0, mag} * {64'd0, w};
		if (prod[127:80] != 0) return neg ? -SAT_LIM : SAT_LIM;
		q = prod[79:16];
		if (q > SAT_LIM) return neg ? -SAT_LIM : SAT_LIM;
		if (neg && prod[15:0] != 0) q = q + 1;
		if (q > SAT_LIM) q = SAT_LIM;
		return neg ? -$signed(q) : $signed(q);
	endfunction

	function automatic logic signed [63:0] blend(bit beyond, logic signed [63:0] a,
			logic signed [63:0] b, logic [63:0] w);
		return clamp_acc((beyond ? b : a) + scale_frac(b - a, w));
	endfunction

	function automatic logic signed [63:0] cell_acc(int r, int c);
		return $signed({18'd0, lat_tab[r][c], 14'd0});
	endfunction

	function automatic estimate_t estimate_latency(logic [23:0] n, logic [15:0] k);
		estimate_t res;
		int rl, rh, cl, ch;
		logic [63:0] rf, cf;
		bit rin, cin;
		logic signed [63:0] e0, e1, acc, ns;
		res.lat = '0;
		res.st = 1'b0;
		if (n == 0 || k == 0) return res;
		if (n < row_bp[0] || k < col_bp[0]) begin
			res.st = 1'b1;
			return res;
		end
		bracket(1'b1, {8'd0, n}, rl, rh, rf, rin);
		bracket(1'b0, {16'd0, k}, cl, ch, cf, cin);
		if (rin && !cin) begin
			e0 = blend(1'b1, cell_acc(rl, cl), cell_acc(rl, ch), cf);
			e1 = blend(1'b1, cell_acc(rh, cl), cell_acc(rh, ch), cf);
			acc = blend(1'b0, e0, e1, rf);
		end else begin
			e0 = blend(!rin, cell_acc(rl, cl), cell_acc(rh, cl), rf);
			e1 = blend(!rin, cell_acc(rl, ch), cell_acc(rh, ch), rf);
			acc = blend(!cin, e0, e1, cf);
		end
		ns = acc >>> gbie_pkg::ACC_BITS;
		if (ns > $signed(gbie_pkg::OUT_MAX)) ns = $signed(gbie_pkg::OUT_MAX);
		if (ns < -$signed(gbie_pkg::OUT_MAX) - 1) ns = -$signed(gbie_pkg::OUT_MAX) - 1;
		res.lat = ns[47:0];
		return res;
	endfunction

	function automatic void apply_request(request_t q);
		case (q.kind)
			gbie_pkg::REQ_ROW_BP: row_bp[q.ri] = q.wv[23:0];
			gbie_pkg::REQ_COL_BP: col_bp[q.ci] = q.wv[15:0];
			gbie_pkg::REQ_CELL: lat_tab[q.ri][q.ci] = q.wv;
			default: pending_estimates.push_back(estimate_latency(q.n, q.k));
		endcase
	endfunction

	always @(posedge clk) begin
		estimate_t exp_res;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_estimates.size() == 0) begin
				$error("unexpected result: latency_ns %0d status %0d", latency_ns, status);
				errors++;
			end else begin
				exp_res = pending_estimates.pop_front();
				if (latency_ns !== exp_res.lat) begin
					$error("latency_ns expected %0d actual %0d", exp_res.lat, latency_ns);
					errors++;
				end
				if (status !== exp_res.st) begin
					$error("status expected %0d actual %0d", exp_res.st, status);
					errors++;
				end
			end
		end
	end

	task automatic send_request(request_t q);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid = 1'b1;
		req_type = q.kind;
		row_index = q.ri;
		col_index = q.ci;
		write_value = q.wv;
		query_n = q.n;
		query_k = q.k;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		apply_request(q);
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		wait (pending_estimates.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic idx, logic [4:0] val);
		settle();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == gbie_pkg::CFG_ROW_USED)
			rows_reg = val;
		else
			cols_reg = val;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic request_t make_query(logic [23:0] n, logic [15:0] k);
		request_t q;
		q.kind = gbie_pkg::REQ_QUERY;
		q.ri = 4'($urandom);
		q.ci = 4'($urandom);
		q.wv = $urandom;
		q.n = n;
		q.k = k;
		return q;
	endfunction

	function automatic request_t make_write(gbie_pkg::req_t kind, int r, int c, logic [31:0] v);
		request_t q;
		q = make_query(24'($urandom), 16'($urandom));
		q.kind = kind;
		q.ri = r[3:0];
		q.ci = c[3:0];
		q.wv = v;
		return q;
	endfunction

	function automatic logic [23:0] pick_n();
		int sel;
		int last;
		sel = $urandom_range(99);
		last = row_bp[points_in_use(rows_reg) - 1];
		if (sel < 4) return 24'd0;
		if (sel < 10) return 24'($urandom);
		if (sel < 14) return 24'($urandom_range(row_bp[0]));
		if (sel < 26) return row_bp[$urandom_range(PTS - 1)];
		return 24'($urandom_range(row_bp[0], last + last / 2 + 1));
	endfunction

	function automatic logic [15:0] pick_k();
		int sel;
		int last;
		sel = $urandom_range(99);
		last = col_bp[points_in_use(cols_reg) - 1];
		if (sel < 4) return 16'd0;
		if (sel < 10) return 16'($urandom);
		if (sel < 14) return 16'($urandom_range(col_bp[0]));
		if (sel < 26) return col_bp[$urandom_range(PTS - 1)];
		return 16'($urandom_range(col_bp[0], last + last / 2 + 1));
	endfunction

	function automatic logic [31:0] pick_latency();
		case ($urandom_range(5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			default: return $urandom_range(100000);
		endcase
	endfunction

	task automatic load_breakpoints();
		for (int i = 0; i < PTS; i++)
			send_request(make_write(gbie_pkg::REQ_ROW_BP, i, $urandom_range(PTS - 1),
				1000 + i * i * 500 + $urandom_range(400) + (32'($urandom) << 24)));
		for (int i = 0; i < PTS; i++)
			send_request(make_write(gbie_pkg::REQ_COL_BP, $urandom_range(PTS - 1), i,
				10 + i * 300 + $urandom_range(200) + (32'($urandom) << 16)));
	endtask

	task automatic test_table_load();
		load_breakpoints();
		for (int r = 0; r < PTS; r++)
			for (int c = 0; c < PTS; c++)
				send_request(make_write(gbie_pkg::REQ_CELL, r, c, pick_latency()));
	endtask

	task automatic test_directed_queries();
		int rl, cl;
		write_register(gbie_pkg::CFG_ROW_USED, 5'd4);
		write_register(gbie_pkg::CFG_COL_USED, 5'd5);
		rl = row_bp[3];
		cl = col_bp[4];
		send_request(make_query(24'd0, 16'd50));
		send_request(make_query(24'd5000, 16'd0));
		send_request(make_query(24'd0, 16'd0));
		send_request(make_query(24'(row_bp[0] - 1), col_bp[1]));
		send_request(make_query(row_bp[1], 16'(col_bp[0] - 1)));
		send_request(make_query(row_bp[0], col_bp[0]));
		send_request(make_query(row_bp[1], col_bp[2]));
		send_request(make_query(24'(rl), 16'(cl)));
		send_request(make_query(24'((row_bp[1] + row_bp[2]) / 2),
			16'((col_bp[2] + col_bp[3]) / 2)));
		send_request(make_query(24'(rl + 700), 16'(col_bp[1] + 17)));
		send_request(make_query(24'(row_bp[2] + 3), 16'(cl + 900)));
		send_request(make_query(24'(rl + 5000), 16'(cl + 5000)));
		send_request(make_query(24'hFF_FFFF, 16'hFFFF));
		send_request(make_query(24'hFF_FFFF, col_bp[1]));
		send_request(make_query(row_bp[2], 16'hFFFF));
		send_request(make_write(gbie_pkg::REQ_CELL, 3, 4, 32'hFFFF_FFFF));
		send_request(make_write(gbie_pkg::REQ_CELL, 2, 4, 32'd0));
		send_request(make_query(24'(rl + 60000), 16'(cl + 20000)));
		send_request(make_query(24'(rl), 16'(cl + 60000)));
	endtask

	task automatic run_mix(int count, int write_pct);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < write_pct)
				send_request(make_write(gbie_pkg::REQ_CELL, $urandom_range(PTS - 1),
					$urandom_range(PTS - 1), pick_latency()));
			else
				send_request(make_query(pick_n(), pick_k()));
		end
	endtask

	task automatic test_register_sweep();
		logic [4:0] rows_set [6] = '{5'd0, 5'd2, 5'd16, 5'd1, 5'd7, 5'd31};
		logic [4:0] cols_set [6] = '{5'd31, 5'd2, 5'd16, 5'd17, 5'd3, 5'd0};
		for (int s = 0; s < 6; s++) begin
			write_register(gbie_pkg::CFG_ROW_USED, rows_set[s]);
			write_register(gbie_pkg::CFG_COL_USED, cols_set[s]);
			run_mix(15, 10);
		end
	endtask

	task automatic test_idle_phases();
		int idle_set [4] = '{0, 82, 0, 28};
		int stall_set [4] = '{0, 0, 82, 28};
		write_register(gbie_pkg::CFG_ROW_USED, 5'd16);
		write_register(gbie_pkg::CFG_COL_USED, 5'd16);
		for (int p = 0; p < 4; p++) begin
			idle_pct = idle_set[p];
			stall_pct = stall_set[p];
			run_mix(40, 15);
		end
		idle_pct = 0;
		stall_pct = 0;
	endtask

	task automatic test_unordered_breakpoints();
		write_register(gbie_pkg::CFG_ROW_USED, 5'd6);
		write_register(gbie_pkg::CFG_COL_USED, 5'd6);
		for (int i = 0; i < 40; i++) begin
			if ($urandom_range(2) == 0)
				send_request(make_write($urandom_range(1) ? gbie_pkg::REQ_ROW_BP
					: gbie_pkg::REQ_COL_BP,
					$urandom_range(PTS - 1), $urandom_range(PTS - 1),
					$urandom_range(20000)));
			else
				send_request(make_query(pick_n(), pick_k()));
		end
		load_breakpoints();
	endtask

	task automatic test_output_hold();
		settle();
		hold_cnt = 3000;
		run_mix(25, 0);
		stall_pct = 30;
		idle_pct = 30;
		run_mix(60, 20);
		stall_pct = 0;
		idle_pct = 0;
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		idle_pct = 0;
		stall_pct = 0;
		hold_cnt = 0;
		rows_reg = 5'd2;
		cols_reg = 5'd2;
		for (int r = 0; r < PTS; r++) begin
			row_bp[r] = '0;
			col_bp[r] = '0;
			for (int c = 0; c < PTS; c++)
				lat_tab[r][c] = '0;
		end
		arst_n = 1'b0;
		out_stall = 1'b0;
		in_valid = 1'b0;
		req_type = '0;
		row_index = '0;
		col_index = '0;
		write_value = '0;
		query_n = '0;
		query_k = '0;
		cfg_valid = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_table_load();
		run_mix(20, 0);
		test_directed_queries();
		test_register_sweep();
		test_idle_phases();
		test_unordered_breakpoints();
		test_output_hold();
		settle();

		if (errors == 0)
			$display("** grid_bilinear_interp_extrap: PASSED **");
		else
			$display("** grid_bilinear_interp_extrap: FAILED **");
		$finish;
	end

endmodule
